>>> rtl/hrfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_pkg
// Shared types, codes and constants of the HTTP request framing parser.
// ----------------------------------------------------------------------------
package hrfp_pkg;

  // Default width of the body length counter and Content-Length value
  localparam int unsigned LENGTH_BITS_DEF = 32;
  // Width of the body_length output field
  localparam int unsigned BODY_LEN_W = 32;

  // Byte roles
  localparam logic [2:0] ROLE_REQ     = 3'd0;
  localparam logic [2:0] ROLE_HDR     = 3'd1;
  localparam logic [2:0] ROLE_DELIM   = 3'd2;
  localparam logic [2:0] ROLE_BODY    = 3'd3;
  localparam logic [2:0] ROLE_DISCARD = 3'd4;

  // Error kinds
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_REQ  = 2'd1;
  localparam logic [1:0] ERR_HDR  = 2'd2;
  localparam logic [1:0] ERR_SEP  = 2'd3;

  // Characters
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

  // Header name match tracking
  localparam logic [4:0] NAME_LEN  = 5'd14;
  localparam logic [4:0] NAME_HIT  = 5'd15;
  localparam logic [4:0] NAME_MISS = 5'd31;

  // Colon tracking within a header line
  localparam logic [1:0] COLON_NONE  = 2'd0;
  localparam logic [1:0] COLON_SEEN  = 2'd1;
  localparam logic [1:0] COLON_SPACE = 2'd2;
  localparam logic [1:0] COLON_BAD   = 2'd3;

  // Control from the framing logic to the length value parser
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } lp_ctrl_t;

  // Lower-case "content-length", one character per position
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hrfp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_in_stage
// Input register: holds one incoming word until the framing stage takes it.
// ----------------------------------------------------------------------------
module hrfp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            fwd_valid_o,
  output logic [7:0]      fwd_byte_o,
  input  wire logic       fwd_ready_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // Accept when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || fwd_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fwd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the byte
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign fwd_valid_o = valid_q;
  assign fwd_byte_o  = byte_q;

endmodule
`default_nettype wire

>>> rtl/hrfp_len_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_len_parse
// Content-Length value parser: skips whitespace, takes an optional sign and
// accumulates decimal digits, saturating at the largest length.
// ----------------------------------------------------------------------------
module hrfp_len_parse
  import hrfp_pkg::*;
#(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire lp_ctrl_t              ctrl_i,
  output logic [LengthBits-1:0]      acc_o,
  output logic                       neg_o
);

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_PLUS,
    MODE_MINUS,
    MODE_DIG_POS,
    MODE_DIG_NEG,
    MODE_DONE_POS,
    MODE_DONE_NEG
  } mode_e;

  localparam int unsigned ProdW = LengthBits + 4;

  mode_e                 mode_q, mode_d;
  logic [LengthBits-1:0] acc_q, acc_d;
  logic [7:0]            c;
  logic                  is_digit;
  logic                  is_ws;
  logic                  is_neg_mode;
  logic [ProdW-1:0]      acc_ext;
  logic [ProdW-1:0]      prod;
  logic                  sat;

  assign c           = ctrl_i.data;
  assign is_digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_ws       = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_neg_mode = (mode_q == MODE_MINUS) || (mode_q == MODE_DIG_NEG);

  // acc * 10 + digit, saturate on overflow of the length width
  assign acc_ext = {4'b0000, acc_q};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + ProdW'(c - CHAR_ZERO);
  assign sat     = |prod[ProdW-1:LengthBits];

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    if (ctrl_i.clear) begin
      mode_d = MODE_SKIP;
      acc_d  = '0;
    end else if (ctrl_i.feed && (mode_q != MODE_DONE_POS) && (mode_q != MODE_DONE_NEG)) begin
      if ((mode_q == MODE_SKIP) && is_ws) begin
        mode_d = MODE_SKIP;
      end else if ((mode_q == MODE_SKIP) && (c == CHAR_PLUS)) begin
        mode_d = MODE_PLUS;
      end else if ((mode_q == MODE_SKIP) && (c == CHAR_MINUS)) begin
        mode_d = MODE_MINUS;
      end else if (!is_digit) begin
        mode_d = is_neg_mode ? MODE_DONE_NEG : MODE_DONE_POS;
      end else begin
        if ((mode_q == MODE_SKIP) || (mode_q == MODE_PLUS)) begin
          mode_d = MODE_DIG_POS;
        end else if (mode_q == MODE_MINUS) begin
          mode_d = MODE_DIG_NEG;
        end
        acc_d = sat ? '1 : prod[LengthBits-1:0];
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SKIP;
      acc_q  <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  assign acc_o = acc_q;
  assign neg_o = (mode_q == MODE_MINUS) || (mode_q == MODE_DIG_NEG) ||
                 (mode_q == MODE_DONE_NEG);

endmodule
`default_nettype wire

>>> rtl/hrfp_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_frame
// Framing state machine and result register: tags each word, checks the
// request line and headers, tracks the body and flags sticky errors.
// ----------------------------------------------------------------------------
module hrfp_frame
  import hrfp_pkg::*;
#(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fwd_valid_i,
  output logic                       fwd_ready_o,
  input  wire logic [7:0]            fwd_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [2:0]                 byte_role_o,
  output logic                       request_done_o,
  output logic                       parse_error_o,
  output logic [1:0]                 error_kind_o,
  output logic [BODY_LEN_W-1:0]      body_length_o
);

  typedef enum logic [2:0] {
    PH_REQ,
    PH_REQ_CR,
    PH_HDR_START,
    PH_BLANK_CR,
    PH_HDR,
    PH_HDR_CR,
    PH_BODY
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [1:0]            err_q, err_d;
  logic                  line_q, line_d;
  logic [1:0]            space_q, space_d;
  logic [1:0]            colon_q, colon_d;
  logic [4:0]            pos_q, pos_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LengthBits-1:0] cnt_q, cnt_d;

  logic                  out_valid_q;
  logic [7:0]            out_byte_q;
  logic [2:0]            role_q, role_d;
  logic                  done_q, done_d;
  logic [1:0]            kind_q, kind_d;
  logic [BODY_LEN_W-1:0] blen_q, blen_d;
  logic [LengthBits-1:0] blen_w;

  logic                  take;
  logic [7:0]            b;
  lp_ctrl_t              lp_ctrl;
  logic [LengthBits-1:0] lp_acc;
  logic                  lp_neg;

  logic                  fin_ok;
  logic [LengthBits-1:0] fin_len;
  logic [1:0]            base_colon;
  logic [4:0]            base_pos;
  logic [7:0]            lower;
  logic [1:0]            tk_colon;
  logic [4:0]            tk_pos;
  logic                  tk_feed;

  assign b           = fwd_byte_i;
  assign fwd_ready_o = !out_valid_q || out_ready_i;
  assign take        = fwd_valid_i && fwd_ready_o;

  // Length value parser
  hrfp_len_parse #(
    .LengthBits (LengthBits)
  ) u_len_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (take),
    .ctrl_i (lp_ctrl),
    .acc_o  (lp_acc),
    .neg_o  (lp_neg)
  );

  // Finish the previous header line: check it and pick up its length
  assign fin_ok  = !line_q || (colon_q == COLON_SPACE);
  assign fin_len = (line_q && (pos_q == NAME_HIT)) ? (lp_neg ? '0 : lp_acc) : len_q;

  // Take a header byte; a new line starts from cleared header state
  assign base_colon = (phase_q == PH_HDR_START) ? COLON_NONE : colon_q;
  assign base_pos   = (phase_q == PH_HDR_START) ? 5'd0 : pos_q;
  assign lower      = ((b >= CHAR_UC_A) && (b <= CHAR_UC_Z)) ? b + 8'd32 : b;

  always_comb begin
    tk_colon = base_colon;
    tk_pos   = base_pos;
    tk_feed  = 1'b0;
    case (base_colon)
      COLON_NONE: begin
        if (b == CHAR_COLON) begin
          tk_colon = COLON_SEEN;
          tk_pos   = (base_pos == NAME_LEN) ? NAME_HIT : NAME_MISS;
        end else if ((base_pos < NAME_LEN) && (lower == name_char(base_pos[3:0]))) begin
          tk_pos = base_pos + 5'd1;
        end else begin
          tk_pos = NAME_MISS;
        end
      end
      COLON_SEEN: begin
        tk_colon = (b == CHAR_SPACE) ? COLON_SPACE : COLON_BAD;
      end
      COLON_SPACE: begin
        tk_feed = (base_pos == NAME_HIT);
      end
      default: begin
        tk_feed = 1'b0;
      end
    endcase
  end

  // Advance the framing state for one byte
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    line_d  = line_q;
    space_d = space_q;
    colon_d = colon_q;
    pos_d   = pos_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    role_d  = ROLE_DELIM;
    kind_d  = ERR_NONE;
    done_d  = 1'b0;
    blen_w  = '0;
    lp_ctrl = '{clear: 1'b0, feed: 1'b0, data: b};

    if (err_q != ERR_NONE) begin
      kind_d = err_q;
    end else begin
      case (phase_q)
        PH_REQ: begin
          if (b == CHAR_CR) begin
            phase_d = PH_REQ_CR;
          end else begin
            line_d = 1'b1;
            role_d = ROLE_REQ;
            if ((b == CHAR_SPACE) && (space_q != 2'd2)) begin
              space_d = space_q + 2'd1;
            end
          end
        end
        PH_REQ_CR: begin
          if ((b == CHAR_LF) && line_q && (space_q == 2'd2)) begin
            phase_d       = PH_HDR_START;
            space_d       = 2'd0;
            line_d        = 1'b0;
            colon_d       = COLON_NONE;
            pos_d         = 5'd0;
            lp_ctrl.clear = 1'b1;
          end else begin
            kind_d = ERR_REQ;
          end
        end
        PH_HDR_START: begin
          if (b == CHAR_CR) begin
            phase_d = PH_BLANK_CR;
          end else if (!fin_ok) begin
            kind_d = ERR_HDR;
          end else begin
            len_d         = fin_len;
            line_d        = 1'b1;
            colon_d       = tk_colon;
            pos_d         = tk_pos;
            lp_ctrl.clear = 1'b1;
            phase_d       = PH_HDR;
            role_d        = ROLE_HDR;
          end
        end
        PH_BLANK_CR: begin
          if (b != CHAR_LF) begin
            kind_d = ERR_SEP;
          end else if (!fin_ok) begin
            kind_d = ERR_HDR;
          end else if (fin_len == '0) begin
            done_d = 1'b1;
          end else begin
            phase_d       = PH_BODY;
            cnt_d         = '0;
            len_d         = fin_len;
            blen_w        = fin_len;
            line_d        = 1'b0;
            colon_d       = COLON_NONE;
            pos_d         = 5'd0;
            lp_ctrl.clear = 1'b1;
          end
        end
        PH_HDR: begin
          if (b == CHAR_CR) begin
            phase_d = PH_HDR_CR;
          end else begin
            line_d       = 1'b1;
            colon_d      = tk_colon;
            pos_d        = tk_pos;
            lp_ctrl.feed = tk_feed;
            role_d       = ROLE_HDR;
          end
        end
        PH_HDR_CR: begin
          if (b == CHAR_LF) begin
            phase_d = PH_HDR_START;
          end else begin
            kind_d = ERR_HDR;
          end
        end
        PH_BODY: begin
          role_d = ROLE_BODY;
          cnt_d  = cnt_q + LengthBits'(1);
          blen_w = len_q;
          if (cnt_d == len_q) begin
            done_d = 1'b1;
          end
        end
        default: begin
          phase_d = PH_REQ;
        end
      endcase
      err_d = kind_d;
    end

    // Drop the byte once an error is in effect
    if (kind_d != ERR_NONE) begin
      role_d = ROLE_DISCARD;
      blen_w = '0;
    end

    // Return to the start after a complete request
    if (done_d) begin
      phase_d       = PH_REQ;
      line_d        = 1'b0;
      space_d       = 2'd0;
      colon_d       = COLON_NONE;
      pos_d         = 5'd0;
      len_d         = '0;
      cnt_d         = '0;
      lp_ctrl.clear = 1'b1;
    end
  end

  // Fit the length to the output field
  if (LengthBits >= BODY_LEN_W) begin : g_blen_trunc
    assign blen_d = blen_w[BODY_LEN_W-1:0];
  end else begin : g_blen_ext
    assign blen_d = {{(BODY_LEN_W - LengthBits){1'b0}}, blen_w};
  end

  // Hold state and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_REQ;
      err_q       <= ERR_NONE;
      line_q      <= 1'b0;
      space_q     <= 2'd0;
      colon_q     <= COLON_NONE;
      pos_q       <= 5'd0;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      role_q      <= ROLE_REQ;
      done_q      <= 1'b0;
      kind_q      <= ERR_NONE;
      blen_q      <= '0;
    end else begin
      if (take) begin
        phase_q     <= phase_d;
        err_q       <= err_d;
        line_q      <= line_d;
        space_q     <= space_d;
        colon_q     <= colon_d;
        pos_q       <= pos_d;
        len_q       <= len_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
        out_byte_q  <= b;
        role_q      <= role_d;
        done_q      <= done_d;
        kind_q      <= kind_d;
        blen_q      <= blen_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_role_o    = role_q;
  assign request_done_o = done_q;
  assign parse_error_o  = (kind_q != ERR_NONE);
  assign error_kind_o   = kind_q;
  assign body_length_o  = blen_q;

endmodule
`default_nettype wire

>>> rtl/http_request_framing_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_framing_parser
// Byte-wide HTTP/1.1 request framer with one tagged result word per byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output side is ready and returns one
// result word per byte, in order: the byte goes through an input register,
// then one pass of the framing logic into the result register. The pass is
// set by the Content-Length digit step (a LengthBits+4 bit shift-add with
// saturation compare) and the body counter increment and compare. Each result
// echoes the byte and tags it as request line, header, delimiter, body or
// discarded; request_done marks the last byte of a request and body, after
// which the parser starts over. Errors are sticky until reset. body_length is
// set on the LF that opens a body and on the body bytes, zero otherwise.
module http_request_framing_parser
  import hrfp_pkg::*;
#(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [2:0]                 byte_role_o,
  output logic                       request_done_o,
  output logic                       parse_error_o,
  output logic [1:0]                 error_kind_o,
  output logic [BODY_LEN_W-1:0]      body_length_o
);

  logic       fwd_valid;
  logic       fwd_ready;
  logic [7:0] fwd_byte;

  // Input register
  hrfp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .fwd_valid_o (fwd_valid),
    .fwd_byte_o  (fwd_byte),
    .fwd_ready_i (fwd_ready)
  );

  // Framing logic and result register
  hrfp_frame #(
    .LengthBits (LengthBits)
  ) u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fwd_valid_i    (fwd_valid),
    .fwd_ready_o    (fwd_ready),
    .fwd_byte_i     (fwd_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_role_o    (byte_role_o),
    .request_done_o (request_done_o),
    .parse_error_o  (parse_error_o),
    .error_kind_o   (error_kind_o),
    .body_length_o  (body_length_o)
  );

endmodule
`default_nettype wire

>>> rtl/hrfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrfp_checker
// Port-level checks of the framing parser, bound to the top level.
// ----------------------------------------------------------------------------
module hrfp_checker
  import hrfp_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [7:0]            out_byte_o,
  input wire logic [2:0]            byte_role_o,
  input wire logic                  request_done_o,
  input wire logic                  parse_error_o,
  input wire logic [1:0]            error_kind_o,
  input wire logic [BODY_LEN_W-1:0] body_length_o
);

  logic err_seen_q;

  // Remember that an error word has been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && parse_error_o) begin
      err_seen_q <= 1'b1;
    end
  end

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(byte_role_o) && $stable(error_kind_o) && $stable(body_length_o))
    else $error("result word changed while stalled");

  // Error flag agrees with error kind
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (parse_error_o == (error_kind_o != ERR_NONE)))
    else $error("parse_error and error_kind disagree");

  // Errored words are discarded and carry no length or completion
  a_err_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_error_o |->
      (byte_role_o == ROLE_DISCARD) && (body_length_o == '0) && !request_done_o)
    else $error("errored word not discarded");

  // Errors are sticky until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && err_seen_q |-> parse_error_o)
    else $error("error cleared without reset");

  // Header and request line bytes carry no body length
  a_no_len_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((byte_role_o == ROLE_REQ) || (byte_role_o == ROLE_HDR)) |->
      (body_length_o == '0) && !request_done_o)
    else $error("length shown before headers end");

endmodule

bind http_request_framing_parser hrfp_checker u_hrfp_checker (.*);
`default_nettype wire

>>> verif/tb_http_request_framing_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_framing_parser
// Self-checking bench for the byte-wide HTTP request framer.
// ----------------------------------------------------------------------------
// Streams well-formed requests with random content into the parser. The
// requests use random request lines, plain headers, near-miss header names and
// Content-Length values in every accepted form, followed by random bodies. A
// scoreboard class predicts the tagged result word of every accepted byte and
// checks the output stream in order. The sender idles in bursts and the
// receiver stalls on its own pattern, with one long hold-off that backs up
// the input. Errors are sticky until reset, so each run closes with a single
// case chosen at random: a saturated body length, or one of the three error
// kinds followed by discarded bytes.
// ----------------------------------------------------------------------------
module tb_http_request_framing_parser;
  import hrfp_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned RANDOM_BYTES    = 820;
  localparam int unsigned HOLD_OFF_START  = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned LEN_BITS        = LENGTH_BITS_DEF;
  localparam longint unsigned LEN_MAX     = (64'd1 << LEN_BITS) - 64'd1;

  // One result word of the parser
  typedef struct packed {
    logic [7:0]            data;
    logic [2:0]            role;
    logic                  done;
    logic                  err;
    logic [1:0]            kind;
    logic [BODY_LEN_W-1:0] blen;
  } parse_word_t;

  // Framing position of the predictor
  typedef enum logic [2:0] {
    PH_REQ_LINE, PH_REQ_CR, PH_LINE_START, PH_BLANK_CR, PH_HDR_LINE, PH_HDR_CR, PH_BODY
  } frame_phase_e;

  // Content-Length value scan, strtoll style
  typedef enum logic [2:0] {
    VAL_SKIP, VAL_PLUS, VAL_MINUS, VAL_DIG_POS, VAL_DIG_NEG, VAL_END_POS, VAL_END_NEG
  } value_mode_e;

  // Shapes of a generated Content-Length value
  typedef enum int unsigned {
    LV_DEC, LV_PLUS, LV_NEG, LV_NONE, LV_HUGE, LV_HUGE_NEG
  } len_form_e;

  // Closing cases of the run
  typedef enum int unsigned {
    CLOSE_SATURATED, CLOSE_REQ_ERR, CLOSE_HDR_ERR, CLOSE_SEP_ERR
  } close_case_e;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the word of each accepted byte and checks results
  // --------------------------------------------------------------------------
  class framing_scoreboard;
    parse_word_t     pending_words[$];
    int unsigned     failures;
    int unsigned     words_checked;
    int unsigned     requests_done;
    int unsigned     body_words;
    string           name_ref = "content-length";

    frame_phase_e    phase;
    logic [1:0]      err_state;
    bit              line_nonempty;
    int unsigned     spaces;
    logic [1:0]      colon_state;
    logic [4:0]      name_pos;
    value_mode_e     vmode;
    longint unsigned acc;
    longint unsigned len_eff;
    longint unsigned body_seen;

    function new();
      reset_state();
    endfunction

    function void clear_line();
      line_nonempty = 1'b0;
      colon_state   = COLON_NONE;
      name_pos      = '0;
      vmode         = VAL_SKIP;
      acc           = 0;
    endfunction

    function void reset_state();
      phase     = PH_REQ_LINE;
      err_state = ERR_NONE;
      spaces    = 0;
      clear_line();
      len_eff   = 0;
      body_seen = 0;
    endfunction

    // Advance the length value scan by one byte
    function void feed_value(logic [7:0] c);
      bit              is_digit;
      longint unsigned d;
      is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      if (vmode == VAL_END_POS || vmode == VAL_END_NEG) return;
      if (vmode == VAL_SKIP) begin
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
        if (c == CHAR_PLUS) begin
          vmode = VAL_PLUS;
          return;
        end
        if (c == CHAR_MINUS) begin
          vmode = VAL_MINUS;
          return;
        end
      end
      if (!is_digit) begin
        vmode = (vmode == VAL_MINUS || vmode == VAL_DIG_NEG) ? VAL_END_NEG : VAL_END_POS;
        return;
      end
      if (vmode == VAL_SKIP || vmode == VAL_PLUS) vmode = VAL_DIG_POS;
      else if (vmode == VAL_MINUS) vmode = VAL_DIG_NEG;
      d = 64'(c - CHAR_ZERO);
      // saturate at the maximum length
      if (acc > (LEN_MAX - d) / 10) acc = LEN_MAX;
      else acc = acc * 10 + d;
    endfunction

    // Track colon, name match and value within a header line
    function void take_header_byte(logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + 8'd32 : c;
      line_nonempty = 1'b1;
      case (colon_state)
        COLON_NONE: begin
          if (c == CHAR_COLON) begin
            colon_state = COLON_SEEN;
            name_pos    = (name_pos == NAME_LEN) ? NAME_HIT : NAME_MISS;
          end else if (name_pos < NAME_LEN && lc == name_ref[name_pos]) begin
            name_pos++;
          end else begin
            name_pos = NAME_MISS;
          end
        end
        COLON_SEEN:  colon_state = (c == CHAR_SPACE) ? COLON_SPACE : COLON_BAD;
        COLON_SPACE: if (name_pos == NAME_HIT) feed_value(c);
        default: ;
      endcase
    endfunction

    // Validate the finished header line and latch its length, if any
    function bit close_header();
      if (!line_nonempty) return 1'b1;
      if (colon_state != COLON_SPACE) return 1'b0;
      if (name_pos == NAME_HIT)
        len_eff = (vmode == VAL_MINUS || vmode == VAL_DIG_NEG || vmode == VAL_END_NEG) ? 0 : acc;
      clear_line();
      return 1'b1;
    endfunction

    // Predict the word for one accepted byte
    function void note_byte(logic [7:0] b);
      parse_word_t w;
      logic [1:0]  kind;
      w      = '0;
      w.data = b;
      w.role = ROLE_DELIM;
      kind   = ERR_NONE;
      if (err_state != ERR_NONE) begin
        kind = err_state;
      end else begin
        case (phase)
          PH_REQ_LINE: begin
            if (b == CHAR_CR) begin
              phase = PH_REQ_CR;
            end else begin
              line_nonempty = 1'b1;
              w.role = ROLE_REQ;
              if (b == CHAR_SPACE && spaces < 2) spaces++;
            end
          end
          PH_REQ_CR: begin
            if (b == CHAR_LF && line_nonempty && spaces == 2) begin
              phase  = PH_LINE_START;
              spaces = 0;
              clear_line();
            end else begin
              kind = ERR_REQ;
            end
          end
          PH_LINE_START: begin
            if (b == CHAR_CR) begin
              phase = PH_BLANK_CR;
            end else if (!close_header()) begin
              kind = ERR_HDR;
            end else begin
              take_header_byte(b);
              phase  = PH_HDR_LINE;
              w.role = ROLE_HDR;
            end
          end
          PH_BLANK_CR: begin
            if (b != CHAR_LF) kind = ERR_SEP;
            else if (!close_header()) kind = ERR_HDR;
            else if (len_eff == 0) w.done = 1'b1;
            else begin
              phase     = PH_BODY;
              body_seen = 0;
              w.blen    = len_eff[BODY_LEN_W-1:0];
            end
          end
          PH_HDR_LINE: begin
            if (b == CHAR_CR) begin
              phase = PH_HDR_CR;
            end else begin
              take_header_byte(b);
              w.role = ROLE_HDR;
            end
          end
          PH_HDR_CR: begin
            if (b == CHAR_LF) phase = PH_LINE_START;
            else kind = ERR_HDR;
          end
          default: begin
            w.role = ROLE_BODY;
            body_seen++;
            w.blen = len_eff[BODY_LEN_W-1:0];
            if (body_seen >= len_eff) w.done = 1'b1;
            body_words++;
          end
        endcase
        if (kind != ERR_NONE) err_state = kind;
      end
      if (kind != ERR_NONE) begin
        w.role = ROLE_DISCARD;
        w.blen = '0;
        w.err  = 1'b1;
      end
      w.kind = kind;
      // a finished request starts over from the request line
      if (w.done) begin
        requests_done++;
        reset_state();
      end
      pending_words.push_back(w);
    endfunction

    function string fmt_word(parse_word_t w);
      return $sformatf("byte=%02h role=%0d done=%0b err=%0b kind=%0d len=%0d",
                       w.data, w.role, w.done, w.err, w.kind, w.blen);
    endfunction

    // Compare one result word with the oldest prediction
    function void check_word(parse_word_t got);
      parse_word_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("[%0t] result word with nothing pending: %s", $time, fmt_word(got));
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("[%0t] word %0d mismatch: expected %s, got %s",
                   $time, words_checked, fmt_word(want), fmt_word(got));
      end
    endfunction

    function void report_leftover();
      if (pending_words.size() != 0) begin
        failures++;
        $display("%0d predicted words never came out", pending_words.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            in_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            out_byte_o;
  logic [2:0]            byte_role_o;
  logic                  request_done_o;
  logic                  parse_error_o;
  logic [1:0]            error_kind_o;
  logic [BODY_LEN_W-1:0] body_length_o;

  framing_scoreboard sb = new();
  int unsigned       bytes_sent;
  int unsigned       burst_left;
  int unsigned       idle_cycles;
  bit                hold_off_req;
  bit                hold_off_done;
  close_case_e       closing;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  http_request_framing_parser #(
    .LengthBits(LEN_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_role_o    (byte_role_o),
    .request_done_o (request_done_o),
    .parse_error_o  (parse_error_o),
    .error_kind_o   (error_kind_o),
    .body_length_o  (body_length_o)
  );

  // Note accepted bytes and check result words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_word({out_byte_o, byte_role_o, request_done_o, parse_error_o,
                       error_kind_o, body_length_o});
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int unsigned run;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        run = HOLD_OFF_CYCLES;
      end else begin
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            out_ready_i <= 1'b1;
            run = $urandom_range(1, 30);
          end
          3: begin
            out_ready_i <= 1'b0;
            run = $urandom_range(1, 4);
          end
          default: begin
            out_ready_i <= 1'($urandom_range(0, 1));
            run = 1;
          end
        endcase
      end
      repeat (run) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Byte pickers
  // --------------------------------------------------------------------------
  // Any line byte but CR, or colon unless allowed, biased toward LF and space
  function automatic logic [7:0] pick_text_byte(bit allow_colon);
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 7))
        0:       b = CHAR_LF;
        1:       b = CHAR_SPACE;
        default: b = 8'($urandom_range(0, 255));
      endcase
    end while (b == CHAR_CR || (!allow_colon && b == CHAR_COLON));
    return b;
  endfunction

  // Whitespace that the value scan skips, CR aside
  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 1)) return CHAR_SPACE;
    return CHAR_TAB + 8'($urandom_range(0, 3));
  endfunction

  // A byte that ends the value scan: no digit, sign, whitespace or CR
  function automatic logic [7:0] pick_stop_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SPACE ||
           (b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_PLUS || b == CHAR_MINUS);
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] pick_not_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_LF);
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one word and hold it until taken; idle between bursts
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic send_crlf();
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
  endtask

  // Three random tokens split by spaces
  task automatic send_request_line();
    for (int t = 0; t < 3; t++) begin
      if (t != 0) push_byte(CHAR_SPACE);
      repeat ($urandom_range(0, 5)) push_byte(pick_text_byte(1'b1));
    end
    send_crlf();
  endtask

  // Content-Length in random case; other flavors miss the name by one byte
  task automatic send_length_name(input int unsigned flavor);
    string      nm;
    logic [7:0] c;
    nm = "content-length";
    case (flavor)
      1:       nm = nm.substr(0, 12);
      2:       nm = {nm, "s"};
      3:       nm = {" ", nm};
      default: ;
    endcase
    for (int i = 0; i < nm.len(); i++) begin
      c = nm[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      push_byte(c);
    end
    push_byte(CHAR_COLON);
    push_byte(CHAR_SPACE);
  endtask

  task automatic send_huge_digits();
    push_byte(CHAR_ZERO + 8'($urandom_range(1, 9)));
    repeat ($urandom_range(10, 19)) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Value text that evaluates to len, to zero, or saturates
  task automatic send_length_value(input int unsigned len, input len_form_e form);
    repeat ($urandom_range(0, 2)) push_byte(pick_blank());
    case (form)
      LV_DEC: begin
        repeat ($urandom_range(0, 2)) push_byte(CHAR_ZERO);
        send_text($sformatf("%0d", len));
      end
      LV_PLUS: begin
        push_byte(CHAR_PLUS);
        send_text($sformatf("%0d", len));
      end
      LV_NEG: begin
        push_byte(CHAR_MINUS);
        send_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      LV_HUGE: begin
        if ($urandom_range(0, 1)) push_byte(CHAR_PLUS);
        send_huge_digits();
      end
      LV_HUGE_NEG: begin
        push_byte(CHAR_MINUS);
        send_huge_digits();
      end
      default: ;
    endcase
    // trailing junk after the number is ignored
    if ($urandom_range(0, 2) == 0) begin
      push_byte(pick_stop_byte());
      repeat ($urandom_range(0, 3)) push_byte(pick_text_byte(1'b1));
    end
    send_crlf();
  endtask

  // Plain header or a near miss of the length name
  task automatic send_other_header();
    if ($urandom_range(0, 3) == 0) begin
      send_length_name($urandom_range(1, 3));
      send_text($sformatf("%0d", $urandom_range(0, 99)));
      send_crlf();
    end else begin
      repeat ($urandom_range(0, 8)) push_byte(pick_text_byte(1'b0));
      push_byte(CHAR_COLON);
      push_byte(CHAR_SPACE);
      repeat ($urandom_range(0, 10)) push_byte(pick_text_byte(1'b1));
      send_crlf();
    end
  endtask

  // One well-formed request with random headers and body
  task automatic send_request();
    int unsigned body_len;
    bit          with_len;
    body_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if ($urandom_range(0, 15) == 0) body_len = $urandom_range(13, 40);
    with_len = (body_len != 0) || $urandom_range(0, 1);
    send_request_line();
    repeat ($urandom_range(0, 2)) send_other_header();
    if (with_len) begin
      // an earlier length header is overridden by the last one
      if ($urandom_range(0, 3) == 0) begin
        send_length_name(0);
        send_length_value(0, $urandom_range(0, 1) ? LV_HUGE : LV_HUGE_NEG);
      end
      send_length_name(0);
      if (body_len != 0) begin
        send_length_value(body_len, $urandom_range(0, 1) ? LV_DEC : LV_PLUS);
      end else begin
        case ($urandom_range(0, 4))
          0:       send_length_value(0, LV_DEC);
          1:       send_length_value(0, LV_PLUS);
          2:       send_length_value(0, LV_NEG);
          3:       send_length_value(0, LV_NONE);
          default: send_length_value(0, LV_HUGE_NEG);
        endcase
      end
    end
    repeat ($urandom_range(0, 2)) send_other_header();
    send_crlf();
    repeat (body_len) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Final case of the run; an error here sticks until the end
  task automatic send_closing_case(input close_case_e sel);
    case (sel)
      CLOSE_SATURATED: begin
        send_request_line();
        send_length_name(0);
        send_length_value(0, LV_HUGE);
        send_crlf();
      end
      CLOSE_REQ_ERR: begin
        case ($urandom_range(0, 2))
          0: begin
            // only one space on the line
            repeat ($urandom_range(1, 4)) push_byte(pick_letter());
            push_byte(CHAR_SPACE);
            repeat ($urandom_range(1, 4)) push_byte(pick_letter());
            send_crlf();
          end
          1: send_crlf();
          default: begin
            send_text("a b c");
            push_byte(CHAR_CR);
            push_byte(pick_not_lf());
          end
        endcase
      end
      CLOSE_HDR_ERR: begin
        send_request_line();
        case ($urandom_range(0, 2))
          0: begin
            // no colon: caught when the next line starts
            repeat ($urandom_range(1, 6)) push_byte(pick_letter());
            send_crlf();
            if ($urandom_range(0, 1)) push_byte(pick_letter());
            else send_crlf();
          end
          1: begin
            // colon not followed by a space
            push_byte(pick_letter());
            push_byte(CHAR_COLON);
            push_byte(pick_letter());
            send_crlf();
            send_crlf();
          end
          default: begin
            send_text("a: b");
            push_byte(CHAR_CR);
            push_byte(pick_not_lf());
          end
        endcase
      end
      default: begin
        send_request_line();
        repeat ($urandom_range(0, 1)) send_other_header();
        push_byte(CHAR_CR);
        push_byte(pick_not_lf());
      end
    endcase
    repeat (40) push_byte(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_byte_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extreme bytes around two spaces, a lone LF kept as data, no body
    push_byte(8'h00);
    push_byte(CHAR_SPACE);
    push_byte(8'hFF);
    push_byte(CHAR_SPACE);
    push_byte(CHAR_LF);
    send_crlf();
    send_crlf();
    // Mixed-case length with a plus sign, body of one CR
    send_text(" / ");
    send_crlf();
    send_text("CONTENT-length: +1");
    send_crlf();
    send_crlf();
    push_byte(CHAR_CR);

    // Random requests; back up the output once along the way
    while (bytes_sent < RANDOM_BYTES) begin
      if (!hold_off_done && bytes_sent >= HOLD_OFF_START) begin
        hold_off_req  = 1'b1;
        hold_off_done = 1'b1;
      end
      send_request();
    end

    closing = close_case_e'($urandom_range(0, 3));
    send_closing_case(closing);
    in_valid_i <= 1'b0;

    // Drain the outstanding words
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.report_leftover();

    $display("Checked %0d words over %0d bytes sent: %0d complete requests, %0d body bytes.",
             sb.words_checked, bytes_sent, sb.requests_done, sb.body_words);
    $display("Run closed with %s after one long output hold-off.", closing.name());
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
